[rtl/core/csp_pkg.sv]
// ----------------------------------------------------------------------------
// csp_pkg: shared types and constants for the call stack self-time profiler
// Holds the table and stack geometry, the memory word layouts, command and
// status codes, and the state machine encoding.
// ----------------------------------------------------------------------------
package csp_pkg;

   // Table and stack geometry
   localparam int FUNC_SLOTS  = 64;
   localparam int STACK_DEPTH = 32;
   localparam int SLOT_W      = $clog2(FUNC_SLOTS);
   localparam int USED_W      = $clog2(FUNC_SLOTS + 1);
   localparam int STK_W       = $clog2(STACK_DEPTH);
   localparam int DEPTH_W     = 6;

   // Payload widths
   localparam int ADDR_W = 64;
   localparam int TIME_W = 64;
   localparam int CNT_W  = 32;

   // Self time is reported in units of this many ticks
   localparam int TICK_DIV  = 1000;
   localparam int REM_W     = $clog2(TICK_DIV);
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = TIME_W / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      CMD_ENTER = 2'd0,
      CMD_EXIT  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_TABLE_FULL = 3'd1,
      ST_STACK_FULL = 3'd2,
      ST_STACK_EMPTY = 3'd3,
      ST_MISMATCH   = 3'd4,
      ST_DISABLED   = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_ENTER,
      S_READ,
      S_EX_STK,
      S_EX_TBL,
      S_EX_SELF,
      S_DIV,
      S_EX_WR,
      S_EX_CAL
   } state_type;

   // Function table word: address and its two counters
   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [CNT_W-1:0]  self_sum;
      logic [CNT_W-1:0]  exits;
   } tbl_word_type;

   // Call stack word
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] entry;
      logic [TIME_W-1:0] callee;
   } stk_word_type;

   localparam int TBL_WORD_W = $bits(tbl_word_type);
   localparam int STK_WORD_W = $bits(stk_word_type);

endpackage

[rtl/core/csp_ram.sv]
// ----------------------------------------------------------------------------
// csp_ram: generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module csp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/call_stack_self_time_profiler_core.sv]
// ----------------------------------------------------------------------------
// call_stack_self_time_profiler_core: function enter/exit self-time profiler
// Keeps a table of function addresses with self-time and exit counters, and
// a call stack of (slot, entry time, callee time) entries.
//
// Usage:
//  - Request: drive req_* and raise start while busy is low; the word is
//    taken then; busy rises next cycle until done, unless answered at once.
//  - Response: exactly one word per request, shown for one cycle with
//    rsp_valid high. The receiver cannot stall; the word must be taken then.
//  - csr_write_enable/csr_write_data set profiling_enabled; write only while
//    the block is idle.
//  - Flow: no-op, disabled, empty-stack exit and unused-slot read answer from
//    idle; read runs S_READ; enter scans the table (one table read per cycle,
//    up to 64 entries), then S_ENTER; exit runs S_EX_STK, S_EX_TBL (a mismatch
//    ends there), S_EX_SELF, divide-by-1000 (4 quotient bits per cycle),
//    S_EX_WR, plus S_EX_CAL with a caller. One request is in flight at a time.
//  - Memories: function table 64 x 128 and call stack 32 x 134, both
//    single-read, single-write with registered read.
//  - Reset: clears the slot count, stack depth and enable. The memories are
//    not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module call_stack_self_time_profiler_core (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_write_enable,
   input  logic                         csr_write_data,
   // request
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_cmd,
   input  logic [csp_pkg::ADDR_W-1:0]   req_func_addr,
   input  logic [csp_pkg::TIME_W-1:0]   req_time_now,
   input  logic [csp_pkg::SLOT_W-1:0]   req_read_slot,
   // response
   output logic                         rsp_valid,
   output logic [2:0]                   rsp_status,
   output logic [csp_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [csp_pkg::DEPTH_W-1:0]  rsp_depth,
   output logic [csp_pkg::CNT_W-1:0]    rsp_self_ticks,
   output logic [csp_pkg::CNT_W-1:0]    rsp_exit_total
);

   csp_pkg::state_type state_ff, state_in;

   // control registers
   logic                         en_ff, en_in;
   logic [csp_pkg::USED_W-1:0]   slots_used_ff, slots_used_in;
   logic [csp_pkg::DEPTH_W-1:0]  depth_ff, depth_in;
   logic                         cmp_valid_ff, cmp_valid_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // payload registers
   csp_pkg::cmd_type             cmd_ff, cmd_in;
   logic [csp_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [csp_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [csp_pkg::SLOT_W-1:0]   rslot_ff, rslot_in;
   logic [csp_pkg::USED_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [csp_pkg::SLOT_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic                         found_ff, found_in;
   logic [csp_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [csp_pkg::CNT_W-1:0]    self_ff, self_in;
   logic [csp_pkg::CNT_W-1:0]    exits_ff, exits_in;
   logic [csp_pkg::TIME_W-1:0]   entry_ff, entry_in;
   logic [csp_pkg::TIME_W-1:0]   callee_ff, callee_in;
   logic [csp_pkg::TIME_W-1:0]   elapsed_ff, elapsed_in;
   logic [csp_pkg::STK_W-1:0]    top_ff, top_in;
   logic [csp_pkg::TIME_W-1:0]   div_ff, div_in;
   logic [csp_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [csp_pkg::CNT_W-1:0]    quo_ff, quo_in;
   logic [csp_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;

   logic [2:0]                   rsp_status_ff, rsp_status_in;
   logic [csp_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [csp_pkg::DEPTH_W-1:0]  rsp_depth_ff, rsp_depth_in;
   logic [csp_pkg::CNT_W-1:0]    rsp_self_ff, rsp_self_in;
   logic [csp_pkg::CNT_W-1:0]    rsp_exit_ff, rsp_exit_in;

   // memory ports
   logic                         tbl_we;
   logic [csp_pkg::SLOT_W-1:0]   tbl_waddr, tbl_raddr;
   csp_pkg::tbl_word_type        tbl_wdata, tbl_rdata;
   logic                         stk_we;
   logic [csp_pkg::STK_W-1:0]    stk_waddr, stk_raddr;
   csp_pkg::stk_word_type        stk_wdata, stk_rdata;

   // decode helpers
   logic                         accept;
   csp_pkg::cmd_type             req_cmd_t;
   logic                         scan_hit, scan_issue, scan_miss;
   logic                         tbl_full, stk_full, div_last;
   logic [csp_pkg::TIME_W-1:0]   div_next;
   logic [csp_pkg::REM_W-1:0]    rem_next;
   logic [csp_pkg::CNT_W-1:0]    quo_next;

   assign accept    = start && (state_ff == csp_pkg::S_IDLE);
   assign req_cmd_t = csp_pkg::cmd_type'(req_cmd);
   assign tbl_full  = (slots_used_ff >= csp_pkg::USED_W'(csp_pkg::FUNC_SLOTS));
   assign stk_full  = (depth_ff >= csp_pkg::DEPTH_W'(csp_pkg::STACK_DEPTH));
   assign div_last  = (cnt_ff == csp_pkg::DIV_CNT_W'(csp_pkg::DIV_STEPS - 1));

   // Table scan: one read issued per cycle, compared in the next cycle
   assign scan_hit   = cmp_valid_ff && (tbl_rdata.addr == addr_ff);
   assign scan_issue = !scan_hit && (scan_idx_ff < slots_used_ff);
   assign scan_miss  = !scan_hit && !scan_issue;

   // Divide by the tick divisor: restoring long division, DIV_BITS per cycle
   always_comb begin
      logic [csp_pkg::TIME_W-1:0]  d;
      logic [csp_pkg::REM_W:0]     r;
      logic [csp_pkg::CNT_W-1:0]   q;
      d = div_ff;
      r = {1'b0, rem_ff};
      q = quo_ff;
      for (int k = 0; k < csp_pkg::DIV_BITS; k++) begin
         r = {r[csp_pkg::REM_W-1:0], d[csp_pkg::TIME_W-1]};
         d = {d[csp_pkg::TIME_W-2:0], 1'b0};
         if (r >= (csp_pkg::REM_W+1)'(csp_pkg::TICK_DIV)) begin
            r = r - (csp_pkg::REM_W+1)'(csp_pkg::TICK_DIV);
            q = {q[csp_pkg::CNT_W-2:0], 1'b1};
         end else begin
            q = {q[csp_pkg::CNT_W-2:0], 1'b0};
         end
      end
      div_next = d;
      rem_next = r[csp_pkg::REM_W-1:0];
      quo_next = q;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csp_pkg::S_IDLE: begin
            if (accept) begin
               unique case (req_cmd_t)
                  csp_pkg::CMD_READ: begin
                     if ({1'b0, req_read_slot} < slots_used_ff) begin
                        state_in = csp_pkg::S_READ;
                     end
                  end
                  csp_pkg::CMD_ENTER: begin
                     if (en_ff) begin
                        state_in = csp_pkg::S_SCAN;
                     end
                  end
                  csp_pkg::CMD_EXIT: begin
                     if (en_ff && depth_ff != '0) begin
                        state_in = csp_pkg::S_EX_STK;
                     end
                  end
                  default: state_in = csp_pkg::S_IDLE;
               endcase
            end
         end
         csp_pkg::S_SCAN: begin
            if (scan_hit || scan_miss) begin
               state_in = csp_pkg::S_ENTER;
            end
         end
         csp_pkg::S_ENTER:   state_in = csp_pkg::S_IDLE;
         csp_pkg::S_READ:    state_in = csp_pkg::S_IDLE;
         csp_pkg::S_EX_STK:  state_in = csp_pkg::S_EX_TBL;
         csp_pkg::S_EX_TBL: begin
            if (tbl_rdata.addr == addr_ff) begin
               state_in = csp_pkg::S_EX_SELF;
            end else begin
               state_in = csp_pkg::S_IDLE;
            end
         end
         csp_pkg::S_EX_SELF: state_in = csp_pkg::S_DIV;
         csp_pkg::S_DIV: begin
            if (div_last) begin
               state_in = csp_pkg::S_EX_WR;
            end
         end
         csp_pkg::S_EX_WR: begin
            if (top_ff != '0) begin
               state_in = csp_pkg::S_EX_CAL;
            end else begin
               state_in = csp_pkg::S_IDLE;
            end
         end
         csp_pkg::S_EX_CAL:  state_in = csp_pkg::S_IDLE;
         default:            state_in = csp_pkg::S_IDLE;
      endcase
   end

   // Datapath, memory controls and response
   always_comb begin
      en_in         = csr_write_enable ? csr_write_data : en_ff;
      slots_used_in = slots_used_ff;
      depth_in      = depth_ff;
      cmp_valid_in  = 1'b0;
      rsp_valid_in  = 1'b0;
      cmd_in        = cmd_ff;
      addr_in       = addr_ff;
      now_in        = now_ff;
      rslot_in      = rslot_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      self_in       = self_ff;
      exits_in      = exits_ff;
      entry_in      = entry_ff;
      callee_in     = callee_ff;
      elapsed_in    = elapsed_ff;
      top_in        = top_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_self_in   = rsp_self_ff;
      rsp_exit_in   = rsp_exit_ff;
      tbl_we        = 1'b0;
      tbl_waddr     = slot_ff;
      tbl_wdata     = tbl_rdata;
      tbl_raddr     = slot_ff;
      stk_we        = 1'b0;
      stk_waddr     = top_ff;
      stk_wdata     = stk_rdata;
      stk_raddr     = top_ff;

      unique case (state_ff)
         // Take a request word; answer no-op, disabled, empty-stack and unused-slot cases at once
         csp_pkg::S_IDLE: begin
            if (accept) begin
               cmd_in      = req_cmd_t;
               addr_in     = req_func_addr;
               now_in      = req_time_now;
               rslot_in    = req_read_slot;
               scan_idx_in = '0;
               tbl_raddr   = req_read_slot;
               stk_raddr   = csp_pkg::STK_W'(depth_ff - csp_pkg::DEPTH_W'(1));
               top_in      = csp_pkg::STK_W'(depth_ff - csp_pkg::DEPTH_W'(1));
               rsp_status_in = csp_pkg::ST_OK;
               rsp_slot_in   = '0;
               rsp_depth_in  = depth_ff;
               rsp_self_in   = '0;
               rsp_exit_in   = '0;
               unique case (req_cmd_t)
                  csp_pkg::CMD_READ: begin
                     rsp_slot_in = req_read_slot;
                     if (!({1'b0, req_read_slot} < slots_used_ff)) begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  csp_pkg::CMD_ENTER: begin
                     if (!en_ff) begin
                        rsp_status_in = csp_pkg::ST_DISABLED;
                        rsp_valid_in  = 1'b1;
                     end
                  end
                  csp_pkg::CMD_EXIT: begin
                     if (!en_ff) begin
                        rsp_status_in = csp_pkg::ST_DISABLED;
                        rsp_valid_in  = 1'b1;
                     end else if (depth_ff == '0) begin
                        rsp_status_in = csp_pkg::ST_STACK_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end
                  end
                  default: rsp_valid_in = 1'b1;
               endcase
            end
         end

         // Look the address up in the table
         csp_pkg::S_SCAN: begin
            tbl_raddr = csp_pkg::SLOT_W'(scan_idx_ff);
            if (scan_issue) begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = csp_pkg::SLOT_W'(scan_idx_ff);
               scan_idx_in  = scan_idx_ff + csp_pkg::USED_W'(1);
            end
            if (scan_hit) begin
               found_in = 1'b1;
               slot_in  = cmp_idx_ff;
               self_in  = tbl_rdata.self_sum;
               exits_in = tbl_rdata.exits;
            end else if (scan_miss) begin
               found_in = 1'b0;
               slot_in  = '0;
               self_in  = '0;
               exits_in = '0;
            end
         end

         // Allocate if needed and push the call
         csp_pkg::S_ENTER: begin
            rsp_valid_in = 1'b1;
            rsp_depth_in = depth_ff;
            rsp_slot_in  = slot_ff;
            rsp_self_in  = self_ff;
            rsp_exit_in  = exits_ff;
            if (!found_ff && tbl_full) begin
               rsp_status_in = csp_pkg::ST_TABLE_FULL;
            end else if (stk_full) begin
               rsp_status_in = csp_pkg::ST_STACK_FULL;
            end else begin
               rsp_status_in = csp_pkg::ST_OK;
               if (!found_ff) begin
                  tbl_we        = 1'b1;
                  tbl_waddr     = csp_pkg::SLOT_W'(slots_used_ff);
                  tbl_wdata     = '{addr: addr_ff, self_sum: '0, exits: '0};
                  slots_used_in = slots_used_ff + csp_pkg::USED_W'(1);
                  rsp_slot_in   = csp_pkg::SLOT_W'(slots_used_ff);
               end
               stk_we       = 1'b1;
               stk_waddr    = csp_pkg::STK_W'(depth_ff);
               stk_wdata    = '{slot: rsp_slot_in, entry: now_ff, callee: '0};
               depth_in     = depth_ff + csp_pkg::DEPTH_W'(1);
               rsp_depth_in = depth_in;
            end
         end

         // Read and clear a slot
         csp_pkg::S_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = csp_pkg::ST_OK;
            rsp_slot_in   = rslot_ff;
            rsp_depth_in  = depth_ff;
            rsp_self_in   = tbl_rdata.self_sum;
            rsp_exit_in   = tbl_rdata.exits;
            tbl_we        = 1'b1;
            tbl_waddr     = rslot_ff;
            tbl_wdata     = '{addr: tbl_rdata.addr, self_sum: '0, exits: '0};
         end

         // Top of stack is here; fetch its table entry
         csp_pkg::S_EX_STK: begin
            slot_in   = stk_rdata.slot;
            entry_in  = stk_rdata.entry;
            callee_in = stk_rdata.callee;
            tbl_raddr = stk_rdata.slot;
         end

         // Check the address and work out elapsed time
         csp_pkg::S_EX_TBL: begin
            self_in    = tbl_rdata.self_sum;
            exits_in   = tbl_rdata.exits;
            elapsed_in = now_ff - entry_ff;
            if (tbl_rdata.addr != addr_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = csp_pkg::ST_MISMATCH;
               rsp_slot_in   = slot_ff;
               rsp_depth_in  = depth_ff;
               rsp_self_in   = tbl_rdata.self_sum;
               rsp_exit_in   = tbl_rdata.exits;
            end
         end

         // Self time = elapsed - callee time, then divide
         csp_pkg::S_EX_SELF: begin
            div_in = elapsed_ff - callee_ff;
            rem_in = '0;
            quo_in = '0;
            cnt_in = '0;
         end

         csp_pkg::S_DIV: begin
            div_in = div_next;
            rem_in = rem_next;
            quo_in = quo_next;
            cnt_in = cnt_ff + csp_pkg::DIV_CNT_W'(1);
         end

         // Update counters, pop, fetch the caller
         csp_pkg::S_EX_WR: begin
            self_in   = self_ff + quo_ff;
            exits_in  = exits_ff + csp_pkg::CNT_W'(1);
            tbl_we    = 1'b1;
            tbl_waddr = slot_ff;
            tbl_wdata = '{addr: addr_ff, self_sum: self_in, exits: exits_in};
            depth_in  = csp_pkg::DEPTH_W'(top_ff);
            stk_raddr = top_ff - csp_pkg::STK_W'(1);
            if (top_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = csp_pkg::ST_OK;
               rsp_slot_in   = slot_ff;
               rsp_depth_in  = depth_in;
               rsp_self_in   = self_in;
               rsp_exit_in   = exits_in;
            end
         end

         // Charge the elapsed time to the caller
         csp_pkg::S_EX_CAL: begin
            stk_we        = 1'b1;
            stk_waddr     = top_ff - csp_pkg::STK_W'(1);
            stk_wdata     = '{slot: stk_rdata.slot, entry: stk_rdata.entry,
                              callee: stk_rdata.callee + elapsed_ff};
            rsp_valid_in  = 1'b1;
            rsp_status_in = csp_pkg::ST_OK;
            rsp_slot_in   = slot_ff;
            rsp_depth_in  = depth_ff;
            rsp_self_in   = self_ff;
            rsp_exit_in   = exits_ff;
         end

         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= csp_pkg::S_IDLE;
         en_ff         <= 1'b0;
         slots_used_ff <= '0;
         depth_ff      <= '0;
         cmp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         en_ff         <= en_in;
         slots_used_ff <= slots_used_in;
         depth_ff      <= depth_in;
         cmp_valid_ff  <= cmp_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      now_ff        <= now_in;
      rslot_ff      <= rslot_in;
      scan_idx_ff   <= scan_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      found_ff      <= found_in;
      slot_ff       <= slot_in;
      self_ff       <= self_in;
      exits_ff      <= exits_in;
      entry_ff      <= entry_in;
      callee_ff     <= callee_in;
      elapsed_ff    <= elapsed_in;
      top_ff        <= top_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_self_ff   <= rsp_self_in;
      rsp_exit_ff   <= rsp_exit_in;
   end

   // Function table: address and counters per slot
   csp_ram #(
      .WIDTH (csp_pkg::TBL_WORD_W),
      .DEPTH (csp_pkg::FUNC_SLOTS)
   ) u_tbl_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   // Call stack
   csp_ram #(
      .WIDTH (csp_pkg::STK_WORD_W),
      .DEPTH (csp_pkg::STACK_DEPTH)
   ) u_stk_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   assign busy           = (state_ff != csp_pkg::S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_depth      = rsp_depth_ff;
   assign rsp_self_ticks = rsp_self_ff;
   assign rsp_exit_total = rsp_exit_ff;

endmodule

[rtl/core/csp_checker.sv]
// ----------------------------------------------------------------------------
// csp_checker: port-level checks for the self-time profiler
// Watches the request and response ports and flags broken behavior.
// ----------------------------------------------------------------------------
module csp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [1:0]                   req_cmd,
   input logic                         rsp_valid,
   input logic [2:0]                   rsp_status,
   input logic [csp_pkg::SLOT_W-1:0]   rsp_slot,
   input logic [csp_pkg::DEPTH_W-1:0]  rsp_depth,
   input logic [csp_pkg::CNT_W-1:0]    rsp_self_ticks,
   input logic [csp_pkg::CNT_W-1:0]    rsp_exit_total
);

   // A response word only appears once the request has finished
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while busy");

   // A no-op is answered on the next cycle with ok
   a_nop_fast: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == csp_pkg::CMD_NOP) |=>
         (rsp_valid && rsp_status == csp_pkg::ST_OK))
      else $error("no-op not answered");

   // Disabled events carry no slot and zero counters
   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == csp_pkg::ST_DISABLED) |->
         (rsp_slot == '0 && rsp_self_ticks == '0 && rsp_exit_total == '0))
      else $error("disabled response carries data");

   // Depth never passes the stack size
   a_depth_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_depth <= csp_pkg::DEPTH_W'(csp_pkg::STACK_DEPTH)))
      else $error("depth out of range");

   // An empty-stack exit reports depth zero
   a_empty_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == csp_pkg::ST_STACK_EMPTY) |-> (rsp_depth == '0))
      else $error("stack empty with nonzero depth");

endmodule

bind call_stack_self_time_profiler_core csp_checker u_csp_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_cmd        (req_cmd),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_slot       (rsp_slot),
   .rsp_depth      (rsp_depth),
   .rsp_self_ticks (rsp_self_ticks),
   .rsp_exit_total (rsp_exit_total)
);

[verif/call_stack_self_time_profiler_core_tb.sv]
// ----------------------------------------------------------------------------
// call_stack_self_time_profiler_core_tb: self-checking bench for the profiler
// Directed words cover the corner cases: disabled events, an empty
// stack, a mismatched exit, timestamp wrap, and reads of used and unused
// slots. Random call and return sequences follow. They fill the function
// table and drive the stack to its full depth. Every response word is
// checked against a shadow model of the table and the stack, or against the fixed expected word of a typed row.
// ----------------------------------------------------------------------------
module call_stack_self_time_profiler_core_tb;
   import csp_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int POOL_N      = 80;

   typedef struct {
      status_type      status;
      logic [5:0]      slot;
      logic [5:0]      depth;
      logic [31:0]     self_ticks;
      logic [31:0]     exit_total;
   } rsp_word_t;

   typedef struct {
      cmd_type     cmd;
      logic [63:0] addr;
      logic [63:0] tnow;
      logic [5:0]  rslot;
      bit          typed;
      rsp_word_t   want;
   } dir_row_t;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic csr_write_data = 0;
   logic start = 0;
   logic busy;
   logic [1:0]  req_cmd = 0;
   logic [63:0] req_func_addr = 0;
   logic [63:0] req_time_now = 0;
   logic [5:0]  req_read_slot = 0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [5:0]  rsp_slot;
   logic [5:0]  rsp_depth;
   logic [31:0] rsp_self_ticks;
   logic [31:0] rsp_exit_total;

   call_stack_self_time_profiler_core DUT (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .start, .busy, .req_cmd, .req_func_addr, .req_time_now, .req_read_slot,
      .rsp_valid, .rsp_status, .rsp_slot, .rsp_depth,
      .rsp_self_ticks, .rsp_exit_total
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // shadow profiler state
   bit          prof_en;
   logic [63:0] fn_addr [FUNC_SLOTS];
   int unsigned slots_used;
   logic [31:0] self_sum [FUNC_SLOTS];
   logic [31:0] exit_cnt [FUNC_SLOTS];
   logic [5:0]  stk_slot [STACK_DEPTH];
   logic [63:0] stk_entry [STACK_DEPTH];
   logic [63:0] stk_callee [STACK_DEPTH];
   int unsigned stk_depth;

   rsp_word_t   pending_rsp [$];
   int          mismatches = 0;
   int          cycles = 0;
   int          idle_pct = 0;
   logic [63:0] addr_pool [POOL_N];
   logic [63:0] clk_now = 0;

   function automatic rsp_word_t make_rsp(status_type st, logic [5:0] s, bit counts);
      rsp_word_t r;
      r.status = st;
      r.slot = s;
      r.depth = stk_depth[5:0];
      r.self_ticks = counts ? self_sum[s] : 32'd0;
      r.exit_total = counts ? exit_cnt[s] : 32'd0;
      return r;
   endfunction

   // Applies one event to the shadow state and returns the word it yields
   function automatic rsp_word_t profile_event(cmd_type c, logic [63:0] a,
                                               logic [63:0] t, logic [5:0] rs);
      rsp_word_t r;
      int found;
      int unsigned s, top;
      logic [63:0] elapsed, self_t;
      found = -1;
      if (c == CMD_READ) begin
         if (rs < slots_used) begin
            r = make_rsp(ST_OK, rs, 1);
            self_sum[rs] = 0;
            exit_cnt[rs] = 0;
         end else begin
            r = make_rsp(ST_OK, rs, 0);
         end
         return r;
      end
      if (c == CMD_NOP) return make_rsp(ST_OK, 0, 0);
      if (!prof_en) return make_rsp(ST_DISABLED, 0, 0);
      if (c == CMD_ENTER) begin
         for (int i = 0; i < slots_used; i++)
            if (found < 0 && fn_addr[i] == a) found = i;
         if (found < 0 && slots_used >= FUNC_SLOTS) return make_rsp(ST_TABLE_FULL, 0, 0);
         if (stk_depth >= STACK_DEPTH) begin
            if (found < 0) return make_rsp(ST_STACK_FULL, 0, 0);
            return make_rsp(ST_STACK_FULL, found, 1);
         end
         if (found < 0) begin
            s = slots_used;
            fn_addr[s] = a;
            self_sum[s] = 0;
            exit_cnt[s] = 0;
            slots_used++;
         end else begin
            s = found;
         end
         stk_slot[stk_depth] = s;
         stk_entry[stk_depth] = t;
         stk_callee[stk_depth] = 0;
         stk_depth++;
         return make_rsp(ST_OK, s, 1);
      end
      // function exit
      if (stk_depth == 0) return make_rsp(ST_STACK_EMPTY, 0, 0);
      top = stk_depth - 1;
      s = stk_slot[top];
      if (fn_addr[s] != a) return make_rsp(ST_MISMATCH, s, 1);
      elapsed = t - stk_entry[top];
      self_t = elapsed - stk_callee[top];
      self_sum[s] += 32'(self_t / 64'd1000);
      exit_cnt[s] += 32'd1;
      stk_depth = top;
      if (top > 0) stk_callee[top-1] += elapsed;
      return make_rsp(ST_OK, s, 1);
   endfunction

   // Drives one word, waits for it to be taken, queues its expected response
   task automatic send_word(cmd_type c, logic [63:0] a, logic [63:0] t,
                            logic [5:0] rs, bit typed, rsp_word_t want);
      rsp_word_t r;
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      start <= 1;
      req_cmd <= c;
      req_func_addr <= a;
      req_time_now <= t;
      req_read_slot <= rs;
      do @(posedge clock); while (busy);
      r = profile_event(c, a, t, rs);
      pending_rsp.push_back(typed ? want : r);
   endtask

   // Enable writes only with the block idle
   task automatic set_profiling(bit v);
      start <= 0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      prof_en = v;
   endtask

   // Response checker
   always @(posedge clock) begin
      rsp_word_t w;
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word, status %0d", rsp_status);
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_status !== w.status || rsp_slot !== w.slot || rsp_depth !== w.depth ||
                rsp_self_ticks !== w.self_ticks || rsp_exit_total !== w.exit_total) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st=%0d slot=%0d dep=%0d self=%0d exits=%0d got st=%0d slot=%0d dep=%0d self=%0d exits=%0d",
                           w.status, w.slot, w.depth, w.self_ticks, w.exit_total,
                           rsp_status, rsp_slot, rsp_depth, rsp_self_ticks, rsp_exit_total);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("call_stack_self_time_profiler_core verification failed");
         $finish;
      end
   end

   // Random traffic: mostly matched calls and returns, some noise
   task automatic random_traffic(int n_words, int n_done);
      rsp_word_t none;
      int unsigned p, lim;
      logic [63:0] a;
      none = make_rsp(ST_OK, 0, 0);
      for (int k = 0; k < n_words; k++) begin
         lim = 8 + (n_done + k) / 10;
         if (lim > POOL_N - 1) lim = POOL_N - 1;
         if ($urandom_range(99) < 2) clk_now = {$urandom, $urandom};
         else clk_now += $urandom_range(1, 40000);
         p = $urandom_range(99);
         if (k % 150 == 40) begin
            // deep call chain up to a full stack and back out
            for (int d = 0; d < STACK_DEPTH + 2; d++) begin
               clk_now += $urandom_range(1, 5000);
               send_word(CMD_ENTER, addr_pool[$urandom_range(0, lim)], clk_now, 0, 0, none);
            end
            while (stk_depth > 0) begin
               clk_now += $urandom_range(1, 5000);
               send_word(CMD_EXIT, fn_addr[stk_slot[stk_depth-1]], clk_now, 0, 0, none);
            end
         end else if (p < 48) begin
            send_word(CMD_ENTER, addr_pool[$urandom_range(0, lim)], clk_now, 0, 0, none);
         end else if (p < 88) begin
            if (stk_depth > 0 && $urandom_range(99) < 85) a = fn_addr[stk_slot[stk_depth-1]];
            else a = addr_pool[$urandom_range(0, lim)];
            send_word(CMD_EXIT, a, clk_now, 0, 0, none);
         end else if (p < 97) begin
            send_word(CMD_READ, {$urandom, $urandom}, clk_now, $urandom_range(0, 63), 0, none);
         end else begin
            send_word(CMD_NOP, {$urandom, $urandom}, clk_now, $urandom_range(0, 63), 0, none);
         end
      end
   endtask

   dir_row_t dir_rows [$];

   function automatic dir_row_t row(cmd_type c, logic [63:0] a, logic [63:0] t,
                                    logic [5:0] rs, bit typed, status_type st,
                                    logic [5:0] s);
      dir_row_t d;
      d.cmd = c; d.addr = a; d.tnow = t; d.rslot = rs; d.typed = typed;
      d.want.status = st; d.want.slot = s; d.want.depth = 0;
      d.want.self_ticks = 0; d.want.exit_total = 0;
      return d;
   endfunction

   initial begin
      slots_used = 0;
      stk_depth = 0;
      prof_en = 0;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < POOL_N; i++) addr_pool[i] = {$urandom, $urandom};

      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // after reset: profiling off
      send_word(CMD_ENTER, '1, '1, 0, 1, row(CMD_ENTER, 0, 0, 0, 1, ST_DISABLED, 0).want);
      send_word(CMD_EXIT, 0, 0, 0, 1, row(CMD_EXIT, 0, 0, 0, 1, ST_DISABLED, 0).want);
      send_word(CMD_READ, 0, 0, 6'd63, 1, row(CMD_READ, 0, 0, 0, 1, ST_OK, 6'd63).want);
      send_word(CMD_NOP, '1, '1, 6'd63, 1, row(CMD_NOP, 0, 0, 0, 1, ST_OK, 0).want);
      set_profiling(1);

      dir_rows.push_back(row(CMD_EXIT, '1, 64'd10, 0, 1, ST_STACK_EMPTY, 0));
      dir_rows.push_back(row(CMD_ENTER, 64'd0, 64'd0, 0, 0, ST_OK, 0));
      dir_rows.push_back(row(CMD_ENTER, '1, 64'd5000, 0, 0, ST_OK, 0));
      dir_rows.push_back(row(CMD_EXIT, 64'd0, 64'd9000, 0, 0, ST_OK, 0));       // mismatch
      dir_rows.push_back(row(CMD_EXIT, '1, 64'd1_005_999, 0, 0, ST_OK, 0));
      dir_rows.push_back(row(CMD_EXIT, 64'd0, 64'd2_000_000, 0, 0, ST_OK, 0));
      dir_rows.push_back(row(CMD_ENTER, 64'h5555_5555_5555_5555, '1, 0, 0, ST_OK, 0));
      dir_rows.push_back(row(CMD_EXIT, 64'h5555_5555_5555_5555, 64'd999, 0, 0, ST_OK, 0));
      dir_rows.push_back(row(CMD_ENTER, 64'd0, 64'd100, 0, 0, ST_OK, 0));
      dir_rows.push_back(row(CMD_EXIT, 64'd0, 64'd99, 0, 0, ST_OK, 0));         // wrap
      dir_rows.push_back(row(CMD_READ, 0, 0, 6'd0, 0, ST_OK, 0));
      dir_rows.push_back(row(CMD_READ, 0, 0, 6'd0, 0, ST_OK, 0));
      dir_rows.push_back(row(CMD_READ, '1, '1, 6'd1, 0, ST_OK, 0));
      dir_rows.push_back(row(CMD_READ, 0, 0, 6'd2, 0, ST_OK, 0));
      dir_rows.push_back(row(CMD_READ, 0, 0, 6'd42, 1, ST_OK, 6'd42));
      foreach (dir_rows[i])
         send_word(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].tnow, dir_rows[i].rslot,
                   dir_rows[i].typed, dir_rows[i].want);

      // random phases with changing sender idling and enable
      idle_pct = 0;
      random_traffic(300, 0);
      idle_pct = 72;
      random_traffic(250, 300);
      set_profiling(0);
      random_traffic(40, 550);
      set_profiling(1);
      idle_pct = 26;
      random_traffic(250, 590);
      start <= 0;
      while (pending_rsp.size() != 0) @(posedge clock);  // let everything drain once
      idle_pct = 0;
      random_traffic(100, 840);
      start <= 0;

      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("call_stack_self_time_profiler_core verification clean");
      else
         $display("call_stack_self_time_profiler_core verification failed");
      $finish;
   end

endmodule
